// ===== sv/glfp_pkg.sv =====
package glfp_pkg;

	localparam logic [7:0] SYNC_A = 8'hAA;
	localparam logic [7:0] SYNC_B = 8'h44;
	localparam logic [7:0] SYNC_C = 8'h12;
	localparam logic [7:0] MIN_HDR = 8'd10;
	localparam int unsigned LEN_CAP = 4096;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [12:0] MAX_LEN_RESET = 13'd4096;
	localparam logic [11:0] HDR_ID_LO = 12'd4;
	localparam logic [11:0] HDR_ID_HI = 12'd5;
	localparam logic [11:0] HDR_LEN_LO = 12'd8;
	localparam logic [11:0] HDR_LEN_HI = 12'd9;
	localparam logic [11:0] CRC_BYTES = 12'd4;

	typedef enum logic [2:0] {
		PH_SYNC1 = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_SYNC3 = 3'd2,
		PH_HLEN  = 3'd3,
		PH_HDR   = 3'd4,
		PH_BODY  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_GOOD = 2'd0,
		ST_CRC  = 2'd1,
		ST_DROP = 2'd2
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] message_id;
		logic [11:0] frame_len;
		logic [31:0] sync_error_count;
		logic [31:0] crc_error_count;
	} result_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== sv/gnss_log_frame_parser.sv =====
// Byte-serial framer for binary GNSS log frames.
// The input stream carries one beat per byte: s_axis_tdata is the stream byte and
// s_axis_tuser is the mode bit, where a set bit clears the parse state and both
// error counters and yields no result. The framer hunts for the sync bytes AA 44 12,
// collects the header, body and a 4-byte CRC, and gives one result beat per frame
// on the output stream: status in m_axis_tuser, and message id, frame length and
// the two wrapping error counters in m_axis_tdata.
// The cfg channel writes the maximum frame length; it is always ready and should
// only be written while no frame is in progress.
// Every byte is handled in the cycle it is accepted, one byte per cycle sustained
// while the skid register is empty, set by the byte-wide CRC update and the parse
// state machine. A result is registered before it shows on the output.
// The output register is backed by a one-beat skid register, so input beats keep
// flowing while a result waits; input stalls only when both hold a result.
// Reset clears the parse state, the counters and the output, and sets the maximum
// frame length to 4096.
module gnss_log_frame_parser
	import glfp_pkg::*;
#(
	parameter int unsigned FRAME_LIMIT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
	input  logic        s_axis_tuser,   // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,   // message_id[15:0], frame_len[27:16],
	                                    // sync_error_count[59:28],
	                                    // crc_error_count[91:60], zero[95:92]
	output logic [1:0]  m_axis_tuser,   // frame_status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data
);

	localparam logic [12:0] CAP = (FRAME_LIMIT < LEN_CAP) ? 13'(FRAME_LIMIT) : 13'(LEN_CAP);

	phase_t      phase_q, phase_d;
	logic [11:0] idx_q, idx_d;
	logic [7:0]  hlen_q, hlen_d;
	logic [15:0] body_q, body_d;
	logic [11:0] tlen_q, tlen_d;
	logic [15:0] id_q, id_d;
	logic [31:0] crc_q, crc_d;
	logic [31:0] rcrc_q, rcrc_d;
	logic [31:0] sync_cnt_q, sync_cnt_d;
	logic [31:0] crc_cnt_q, crc_cnt_d;
	logic [12:0] max_len_q;

	result_t     out_q, skid_q, res;
	logic        out_v_q, skid_v_q, res_v;

	logic        s_fire, m_fire, mode;
	logic [7:0]  b;
	logic [31:0] crc_upd, crc_first;
	logic [11:0] idx_inc, crc_start;
	logic [15:0] id_upd, body_upd;
	logic [16:0] total;
	logic [12:0] limit;
	logic        short_hdr, hdr_last, too_long, body_last, in_payload, clr;
	logic [1:0]  pos;
	logic [31:0] rcrc_upd;

	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign m_fire = m_axis_tvalid && m_axis_tready;
	assign mode = s_axis_tuser;
	assign b = s_axis_tdata;

	assign crc_upd = crc_byte(crc_q, b);
	assign crc_first = crc_byte(32'h0, b);
	assign idx_inc = idx_q + 12'd1;

	assign id_upd = (idx_q == HDR_ID_LO) ? {id_q[15:8], b} :
	                (idx_q == HDR_ID_HI) ? {b, id_q[7:0]} : id_q;
	assign body_upd = (idx_q == HDR_LEN_LO) ? {body_q[15:8], b} :
	                  (idx_q == HDR_LEN_HI) ? {b, body_q[7:0]} : body_q;
	assign total = {9'h0, hlen_q} + {1'b0, body_upd} + 17'd4;
	assign limit = (max_len_q < CAP) ? max_len_q : CAP;
	assign short_hdr = b < MIN_HDR;
	assign hdr_last = idx_inc == {4'h0, hlen_q};
	assign too_long = total >= {4'h0, limit};

	assign crc_start = tlen_q - CRC_BYTES;
	assign in_payload = idx_q < crc_start;
	assign pos = 2'(idx_q - crc_start);
	assign rcrc_upd = rcrc_q | ({24'h0, b} << {pos, 3'b000});
	assign body_last = idx_inc == tlen_q;

	always_comb begin
		phase_d = phase_q;
		if (s_fire) begin
			if (mode) begin
				phase_d = PH_SYNC1;
			end else begin
				case (phase_q)
					PH_SYNC2: begin
						phase_d = (b == SYNC_B) ? PH_SYNC3 : ((b == SYNC_A) ? PH_SYNC2 : PH_SYNC1);
					end
					PH_SYNC3: begin
						phase_d = (b == SYNC_C) ? PH_HLEN : ((b == SYNC_A) ? PH_SYNC2 : PH_SYNC1);
					end
					PH_HLEN: begin
						phase_d = short_hdr ? PH_SYNC1 : PH_HDR;
					end
					PH_HDR: begin
						if (hdr_last) begin
							phase_d = too_long ? PH_SYNC1 : PH_BODY;
						end
					end
					PH_BODY: begin
						if (body_last) begin
							phase_d = PH_SYNC1;
						end
					end
					default: begin
						phase_d = (b == SYNC_A) ? PH_SYNC2 : PH_SYNC1;
					end
				endcase
			end
		end
	end

	always_comb begin
		idx_d = idx_q;
		hlen_d = hlen_q;
		body_d = body_q;
		tlen_d = tlen_q;
		id_d = id_q;
		crc_d = crc_q;
		rcrc_d = rcrc_q;
		sync_cnt_d = sync_cnt_q;
		crc_cnt_d = crc_cnt_q;
		clr = 1'b0;
		res_v = 1'b0;
		res.status = ST_GOOD;
		res.message_id = 16'h0;
		res.frame_len = 12'h0;
		if (s_fire) begin
			if (mode) begin
				clr = 1'b1;
				sync_cnt_d = 32'h0;
				crc_cnt_d = 32'h0;
			end else begin
				case (phase_q)
					PH_SYNC2: begin
						if (b == SYNC_B) begin
							crc_d = crc_upd;
						end else begin
							sync_cnt_d = sync_cnt_q + 32'd1;
							if (b == SYNC_A) begin
								crc_d = crc_first;
							end
						end
					end
					PH_SYNC3: begin
						if (b == SYNC_C) begin
							crc_d = crc_upd;
						end else begin
							sync_cnt_d = sync_cnt_q + 32'd1;
							if (b == SYNC_A) begin
								crc_d = crc_first;
							end
						end
					end
					PH_HLEN: begin
						crc_d = crc_upd;
						hlen_d = b;
						id_d = 16'h0;
						body_d = 16'h0;
						rcrc_d = 32'h0;
						idx_d = HDR_ID_LO;
						if (short_hdr) begin
							clr = 1'b1;
							res_v = 1'b1;
							res.status = ST_DROP;
						end
					end
					PH_HDR: begin
						crc_d = crc_upd;
						id_d = id_upd;
						body_d = body_upd;
						idx_d = idx_inc;
						if (hdr_last) begin
							if (too_long) begin
								clr = 1'b1;
								res_v = 1'b1;
								res.status = ST_DROP;
								res.message_id = id_upd;
							end else begin
								tlen_d = total[11:0];
							end
						end
					end
					PH_BODY: begin
						if (in_payload) begin
							crc_d = crc_upd;
						end else begin
							rcrc_d = rcrc_upd;
						end
						idx_d = idx_inc;
						if (body_last) begin
							clr = 1'b1;
							res_v = 1'b1;
							res.message_id = id_q;
							res.frame_len = tlen_q;
							if (rcrc_upd != crc_q) begin
								crc_cnt_d = crc_cnt_q + 32'd1;
								res.status = ST_CRC;
							end
						end
					end
					default: begin
						if (b == SYNC_A) begin
							crc_d = crc_first;
						end else begin
							sync_cnt_d = sync_cnt_q + 32'd1;
						end
					end
				endcase
			end
		end
		if (clr) begin
			idx_d = 12'h0;
			hlen_d = 8'h0;
			body_d = 16'h0;
			tlen_d = 12'h0;
			id_d = 16'h0;
			crc_d = 32'h0;
			rcrc_d = 32'h0;
		end
		res.sync_error_count = sync_cnt_d;
		res.crc_error_count = crc_cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			idx_q <= 12'h0;
			hlen_q <= 8'h0;
			body_q <= 16'h0;
			tlen_q <= 12'h0;
			id_q <= 16'h0;
			crc_q <= 32'h0;
			rcrc_q <= 32'h0;
			sync_cnt_q <= 32'h0;
			crc_cnt_q <= 32'h0;
		end else begin
			phase_q <= phase_d;
			idx_q <= idx_d;
			hlen_q <= hlen_d;
			body_q <= body_d;
			tlen_q <= tlen_d;
			id_q <= id_d;
			crc_q <= crc_d;
			rcrc_q <= rcrc_d;
			sync_cnt_q <= sync_cnt_d;
			crc_cnt_q <= crc_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_fire) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (res_v) begin
			if (!out_v_q || m_fire) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (m_fire) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_fire) begin
				out_q <= skid_q;
			end
		end else if (res_v) begin
			if (!out_v_q || m_fire) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign s_axis_tready = !skid_v_q;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser = out_q.status;
	assign m_axis_tdata = {4'h0, out_q.crc_error_count, out_q.sync_error_count,
		out_q.frame_len, out_q.message_id};

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register holds a result while the output register is empty");

	a_clear_counters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && mode) |=> (sync_cnt_q == 32'h0 && crc_cnt_q == 32'h0 &&
			phase_q == PH_SYNC1))
		else $error("clear beat did not reset the parser");

	a_body_length: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (tlen_q >= 12'd14 && idx_q < tlen_q))
		else $error("body phase with an impossible frame length or index");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("output changed while both result registers were full");

endmodule

// ===== bench/frame_verdict_checker.sv =====
`timescale 1ns / 100ps

package log_crc_pkg;

	function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] r;
		r = crc ^ {24'd0, b};
		repeat (8) begin
			r = {1'b0, r[31:1]} ^ (r[0] ? glfp_pkg::CRC_POLY : 32'd0);
		end
		return r;
	endfunction

endpackage

module frame_verdict_checker
	import glfp_pkg::*;
	import log_crc_pkg::*;
#(
	parameter int unsigned FRAME_LIMIT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [95:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [12:0] cfg_data,
	output int          failures,
	output int          outstanding,
	output int          verdicts
);

	logic [12:0] max_len;
	phase_t      phase;
	logic [11:0] idx;
	logic [7:0]  hdr_len;
	logic [15:0] body_len;
	logic [11:0] total_len;
	logic [15:0] msg_id;
	logic [31:0] run_crc;
	logic [31:0] rx_crc;
	logic [31:0] sync_errs;
	logic [31:0] crc_errs;

	result_t expected_verdicts[$];
	result_t want;
	int      fail_count;
	int      predicted_count;

	task automatic clear_parse();
		phase = PH_SYNC1;
		idx = '0;
		hdr_len = '0;
		body_len = '0;
		total_len = '0;
		msg_id = '0;
		run_crc = '0;
		rx_crc = '0;
	endtask

	task automatic post_verdict(input status_t st, input logic [15:0] id, input logic [11:0] len);
		result_t v;
		v.status = st;
		v.message_id = id;
		v.frame_len = len;
		v.sync_error_count = sync_errs;
		v.crc_error_count = crc_errs;
		expected_verdicts.push_back(v);
		predicted_count++;
	endtask

	task automatic sync_reject(input logic [7:0] b);
		sync_errs = sync_errs + 32'd1;
		if (b == SYNC_A) begin
			run_crc = crc32_update(32'd0, b);
			phase = PH_SYNC2;
		end else begin
			phase = PH_SYNC1;
		end
	endtask

	task automatic predict_frame_verdict(input logic mode, input logic [7:0] b);
		int unsigned lim;
		int unsigned total;
		logic [11:0] off;
		logic [15:0] id;
		status_t     st;
		if (mode) begin
			clear_parse();
			sync_errs = '0;
			crc_errs = '0;
			return;
		end
		case (phase)
			PH_SYNC2: begin
				if (b == SYNC_B) begin
					run_crc = crc32_update(run_crc, b);
					phase = PH_SYNC3;
				end else begin
					sync_reject(b);
				end
			end
			PH_SYNC3: begin
				if (b == SYNC_C) begin
					run_crc = crc32_update(run_crc, b);
					phase = PH_HLEN;
				end else begin
					sync_reject(b);
				end
			end
			PH_HLEN: begin
				run_crc = crc32_update(run_crc, b);
				hdr_len = b;
				msg_id = '0;
				body_len = '0;
				rx_crc = '0;
				idx = HDR_ID_LO;
				if (b < MIN_HDR) begin
					clear_parse();
					post_verdict(ST_DROP, 16'd0, 12'd0);
				end else begin
					phase = PH_HDR;
				end
			end
			PH_HDR: begin
				run_crc = crc32_update(run_crc, b);
				if (idx == HDR_ID_LO) msg_id[7:0] = b;
				if (idx == HDR_ID_HI) msg_id[15:8] = b;
				if (idx == HDR_LEN_LO) body_len[7:0] = b;
				if (idx == HDR_LEN_HI) body_len[15:8] = b;
				idx = idx + 12'd1;
				if (idx == {4'd0, hdr_len}) begin
					lim = max_len;
					if (lim > FRAME_LIMIT) lim = FRAME_LIMIT;
					if (lim > LEN_CAP) lim = LEN_CAP;
					total = hdr_len + body_len + 32'd4;
					if (total >= lim) begin
						id = msg_id;
						clear_parse();
						post_verdict(ST_DROP, id, 12'd0);
					end else begin
						total_len = total[11:0];
						phase = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				if (idx < total_len - CRC_BYTES) begin
					run_crc = crc32_update(run_crc, b);
				end else begin
					off = idx - (total_len - CRC_BYTES);
					rx_crc = rx_crc | ({24'd0, b} << (8 * off[1:0]));
				end
				idx = idx + 12'd1;
				if (idx == total_len) begin
					st = ST_GOOD;
					if (rx_crc != run_crc) begin
						crc_errs = crc_errs + 32'd1;
						st = ST_CRC;
					end
					id = msg_id;
					off = total_len;
					clear_parse();
					post_verdict(st, id, off);
				end
			end
			default: begin
				if (b == SYNC_A) begin
					run_crc = crc32_update(32'd0, b);
					phase = PH_SYNC2;
				end else begin
					sync_errs = sync_errs + 32'd1;
					phase = PH_SYNC1;
				end
			end
		endcase
	endtask

	task automatic report_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp, act);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len = MAX_LEN_RESET;
			clear_parse();
			sync_errs = '0;
			crc_errs = '0;
			expected_verdicts.delete();
			fail_count = 0;
			predicted_count = 0;
			failures <= 0;
			outstanding <= 0;
			verdicts <= 0;
		end else begin
			if (cfg_valid && cfg_ready) max_len = cfg_data;
			if (s_axis_tvalid && s_axis_tready) predict_frame_verdict(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_verdicts.size() == 0) begin
					$display("%0t: result beat with no verdict pending, tuser 0x%0h tdata 0x%0h",
						$time, m_axis_tuser, m_axis_tdata);
					fail_count++;
				end else begin
					want = expected_verdicts.pop_front();
					report_field("frame_status", 32'(want.status), 32'(m_axis_tuser));
					report_field("message_id", 32'(want.message_id), 32'(m_axis_tdata[15:0]));
					report_field("frame_len", 32'(want.frame_len), 32'(m_axis_tdata[27:16]));
					report_field("sync_error_count", want.sync_error_count, m_axis_tdata[59:28]);
					report_field("crc_error_count", want.crc_error_count, m_axis_tdata[91:60]);
				end
			end
			failures <= fail_count;
			outstanding <= expected_verdicts.size();
			verdicts <= predicted_count;
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import glfp_pkg::*;
	import log_crc_pkg::*;

	localparam int unsigned FRAME_LIMIT = 4096;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [95:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [12:0] cfg_data;

	int failures;
	int outstanding;
	int verdicts;

	int max_len_setting = MAX_LEN_RESET;
	int bytes_sent = 0;
	bit src_steady = 0;

	gnss_log_frame_parser #(
		.FRAME_LIMIT(FRAME_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	frame_verdict_checker #(
		.FRAME_LIMIT(FRAME_LIMIT)
	) verdict_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.failures(failures),
		.outstanding(outstanding),
		.verdicts(verdicts)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (src_steady || r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_beat(input logic mode, input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= mode;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	task automatic wait_for_verdicts(input int settle);
		s_axis_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [12:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_len_setting = v;
	endtask

	task automatic send_frame(input int hdr, input int body, input logic [15:0] id,
			input bit bad_crc, input bit abort);
		logic [7:0]  fb[$];
		logic [31:0] crc;
		int          eff;
		int          n;
		eff = max_len_setting;
		if (eff > FRAME_LIMIT) eff = FRAME_LIMIT;
		if (eff > LEN_CAP) eff = LEN_CAP;
		fb = '{SYNC_A, SYNC_B, SYNC_C, 8'(hdr)};
		if (hdr >= MIN_HDR) begin
			for (int i = 4; i < hdr; i++) begin
				case (i)
					HDR_ID_LO:  fb.push_back(id[7:0]);
					HDR_ID_HI:  fb.push_back(id[15:8]);
					HDR_LEN_LO: fb.push_back(8'(body));
					HDR_LEN_HI: fb.push_back(8'(body >> 8));
					default:    fb.push_back(8'($urandom));
				endcase
			end
			if (hdr + body + 4 < eff) begin
				repeat (body) fb.push_back(8'($urandom));
				crc = '0;
				foreach (fb[i]) crc = crc32_update(crc, fb[i]);
				for (int k = 0; k < 4; k++) fb.push_back(crc[8*k +: 8]);
				if (bad_crc) begin
					n = fb.size() - 1 - $urandom_range(0, 3);
					fb[n] = fb[n] ^ (8'd1 << $urandom_range(0, 7));
				end
			end
		end
		n = fb.size();
		if (abort) n = $urandom_range(1, n - 1);
		for (int i = 0; i < n; i++) send_beat(1'b0, fb[i]);
		if (abort) send_beat(1'b1, 8'($urandom));
	endtask

	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			int r;
			r = $urandom_range(0, 99);
			if (r < 40) begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b0;
				if (r < 85) repeat ($urandom_range(1, 3)) @(posedge clk);
				else if (r < 97) repeat ($urandom_range(4, 12)) @(posedge clk);
				else repeat ($urandom_range(20, 80)) @(posedge clk);
			end
		end
	end

	initial begin
		int settings[6];
		int start_bytes;
		int start_verdicts;
		int hdr;
		int body;
		int eff;
		int fits_max;
		int r;

		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Clear beat, sync rejects with and without restart on AA, a short header
		// and a minimal good frame.
		send_beat(1'b1, 8'hFF);
		send_beat(1'b0, SYNC_A);
		send_beat(1'b0, 8'h55);
		send_beat(1'b0, SYNC_A);
		send_beat(1'b0, SYNC_A);
		send_beat(1'b0, SYNC_B);
		send_beat(1'b0, SYNC_A);
		send_beat(1'b0, SYNC_B);
		send_beat(1'b0, SYNC_C);
		send_beat(1'b0, 8'h09);
		send_frame(10, 0, 16'hFFFF, 1'b0, 1'b0);

		settings = '{4096, 8191, 16, 0, 300, $urandom_range(17, 4095)};
		foreach (settings[p]) begin
			wait_for_verdicts(6);
			write_max_len(13'(settings[p]));
			if (settings[p] == 8191) begin
				src_steady = 1'b0;
				send_frame(10, 4082, 16'($urandom), 1'b0, 1'b0);
			end
			eff = max_len_setting;
			if (eff > FRAME_LIMIT) eff = FRAME_LIMIT;
			if (eff > LEN_CAP) eff = LEN_CAP;
			start_bytes = bytes_sent;
			start_verdicts = verdicts;
			while (bytes_sent - start_bytes < 85 || verdicts - start_verdicts < 3) begin
				src_steady = ($urandom_range(0, 4) == 0);
				if ($urandom_range(0, 9) < 3) begin
					repeat ($urandom_range(1, 4)) send_beat(1'b0, 8'($urandom));
				end
				if ($urandom_range(0, 29) == 0) send_beat(1'b1, 8'($urandom));
				r = $urandom_range(0, 99);
				if (r < 10) hdr = $urandom_range(0, 9);
				else if (r < 75) hdr = $urandom_range(10, 14);
				else if (r < 93) hdr = $urandom_range(15, 40);
				else hdr = $urandom_range(200, 255);
				fits_max = eff - hdr - 5;
				r = $urandom_range(0, 99);
				if (fits_max >= 0 && r < 75) begin
					body = $urandom_range(0, (fits_max < 24) ? fits_max : 24);
				end else if (fits_max >= 0 && fits_max <= 300 && r < 82) begin
					body = fits_max;
				end else if (r < 91) begin
					body = eff - hdr - 4;
					if (body < 0) body = 0;
					body = body + $urandom_range(0, 2);
				end else begin
					body = $urandom_range(4096, 65535);
				end
				send_frame(hdr, body, 16'($urandom), $urandom_range(0, 4) == 0,
					$urandom_range(0, 19) == 0);
			end
		end

		wait_for_verdicts(10);
		if (failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/glfp_pkg.sv
sv/gnss_log_frame_parser.sv
bench/frame_verdict_checker.sv
bench/tb.sv
